### hdl/x25sm_pkg.sv
// Shared types, constants and the control program of the X25519 scalar multiplier.
package x25sm_pkg;

  // Field element width and derived constants.
  localparam int unsigned FE_W  = 256;
  localparam int unsigned ACC_W = 262;

  // Four times the field prime, used to keep subtraction nonnegative.
  localparam logic [ACC_W-1:0] FOUR_P = (262'd1 << 257) - 262'd76;

  // Curve constant for the ladder's doubling step.
  localparam logic [FE_W-1:0] A24 = 256'd121666;

  // Low byte of the exponent p-2; all higher bits up to 254 are set.
  localparam logic [7:0] INV_LOW = 8'heb;
  localparam logic [7:0] POS_TOP = 8'd254;

  // Encodings of points with small order, bit 255 excluded.
  localparam int unsigned N_SMALL = 7;
  localparam logic [FE_W-1:0] SMALL_ORDER [N_SMALL] = '{
    256'h0,
    256'h1,
    256'h00b8495f16056286_fdb1329ceb8d09da_6ac49ff1fae35616_aeb8413b7c7aebe0,
    256'h57119fd0dd4e22d8_868e1c58c45c4404_5bef839c55b1d0b1_248c50a3bc959c5f,
    256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffec,
    256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffed,
    256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffee
  };

  // Field unit operations.
  typedef enum logic [2:0] {
    ALU_ADD  = 3'd0,
    ALU_SUB  = 3'd1,
    ALU_MUL  = 3'd2,
    ALU_MULK = 3'd3,
    ALU_FRZ  = 3'd4
  } alu_op_e;

  // Request from the sequencer to the field unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Micro-operations of the control program.
  typedef enum logic [3:0] {
    U_LD0   = 4'd0,
    U_LD1   = 4'd1,
    U_LDP   = 4'd2,
    U_MOV   = 4'd3,
    U_CMOV  = 4'd4,
    U_SETSW = 4'd5,
    U_FINSW = 4'd6,
    U_LOOP  = 4'd7,
    U_SKIPB = 4'd8,
    U_ADD   = 4'd9,
    U_SUB   = 4'd10,
    U_MUL   = 4'd11,
    U_MULK  = 4'd12,
    U_FRZ   = 4'd13,
    U_OUTP  = 4'd14
  } uop_e;

  // One control word.
  typedef struct packed {
    uop_e       op;
    logic [3:0] dst;
    logic [3:0] sa;
    logic [3:0] sb;
    logic [5:0] tgt;
  } uop_t;

  // Register file slots.
  localparam logic [3:0] R_X1  = 4'd0;
  localparam logic [3:0] R_X2  = 4'd1;
  localparam logic [3:0] R_Z2  = 4'd2;
  localparam logic [3:0] R_X3  = 4'd3;
  localparam logic [3:0] R_Z3  = 4'd4;
  localparam logic [3:0] R_A   = 4'd5;
  localparam logic [3:0] R_B   = 4'd6;
  localparam logic [3:0] R_AA  = 4'd7;
  localparam logic [3:0] R_BB  = 4'd8;
  localparam logic [3:0] R_E   = 4'd9;
  localparam logic [3:0] R_DA  = 4'd10;
  localparam logic [3:0] R_CB  = 4'd11;
  localparam logic [3:0] R_T   = 4'd12;
  localparam logic [3:0] R_INV = 4'd13;

  // Program entry points.
  localparam logic [5:0] PC_LADDER = 6'd5;
  localparam logic [5:0] PC_INV    = 6'd39;
  localparam logic [5:0] PC_NOMUL  = 6'd42;

  function automatic uop_t uw(uop_e op, logic [3:0] d, logic [3:0] a, logic [3:0] b,
                              logic [5:0] t);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    u.tgt = t;
    return u;
  endfunction

  // Control program: setup, ladder, final swap, inversion, output.
  function automatic uop_t rom(logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = uw(U_LDP,   R_X1,  R_X1,  R_X1,  6'd0);
      6'd1:  u = uw(U_LD1,   R_X2,  R_X1,  R_X1,  6'd0);
      6'd2:  u = uw(U_LD0,   R_Z2,  R_X1,  R_X1,  6'd0);
      6'd3:  u = uw(U_MOV,   R_X3,  R_X1,  R_X1,  6'd0);
      6'd4:  u = uw(U_LD1,   R_Z3,  R_X1,  R_X1,  6'd0);
      6'd5:  u = uw(U_SETSW, R_T,   R_X1,  R_X1,  6'd0);
      6'd6:  u = uw(U_CMOV,  R_T,   R_X2,  R_X2,  6'd0);
      6'd7:  u = uw(U_CMOV,  R_X2,  R_X3,  R_X3,  6'd0);
      6'd8:  u = uw(U_CMOV,  R_X3,  R_T,   R_T,   6'd0);
      6'd9:  u = uw(U_CMOV,  R_T,   R_Z2,  R_Z2,  6'd0);
      6'd10: u = uw(U_CMOV,  R_Z2,  R_Z3,  R_Z3,  6'd0);
      6'd11: u = uw(U_CMOV,  R_Z3,  R_T,   R_T,   6'd0);
      6'd12: u = uw(U_ADD,   R_A,   R_X2,  R_Z2,  6'd0);
      6'd13: u = uw(U_SUB,   R_B,   R_X2,  R_Z2,  6'd0);
      6'd14: u = uw(U_MUL,   R_AA,  R_A,   R_A,   6'd0);
      6'd15: u = uw(U_MUL,   R_BB,  R_B,   R_B,   6'd0);
      6'd16: u = uw(U_MUL,   R_X2,  R_AA,  R_BB,  6'd0);
      6'd17: u = uw(U_SUB,   R_E,   R_AA,  R_BB,  6'd0);
      6'd18: u = uw(U_SUB,   R_DA,  R_X3,  R_Z3,  6'd0);
      6'd19: u = uw(U_MUL,   R_DA,  R_DA,  R_A,   6'd0);
      6'd20: u = uw(U_ADD,   R_CB,  R_X3,  R_Z3,  6'd0);
      6'd21: u = uw(U_MUL,   R_CB,  R_CB,  R_B,   6'd0);
      6'd22: u = uw(U_ADD,   R_X3,  R_DA,  R_CB,  6'd0);
      6'd23: u = uw(U_MUL,   R_X3,  R_X3,  R_X3,  6'd0);
      6'd24: u = uw(U_SUB,   R_Z3,  R_DA,  R_CB,  6'd0);
      6'd25: u = uw(U_MUL,   R_Z3,  R_Z3,  R_Z3,  6'd0);
      6'd26: u = uw(U_MUL,   R_Z3,  R_Z3,  R_X1,  6'd0);
      6'd27: u = uw(U_MULK,  R_Z2,  R_E,   R_E,   6'd0);
      6'd28: u = uw(U_ADD,   R_Z2,  R_Z2,  R_BB,  6'd0);
      6'd29: u = uw(U_MUL,   R_Z2,  R_Z2,  R_E,   6'd0);
      6'd30: u = uw(U_LOOP,  R_T,   R_X1,  R_X1,  PC_LADDER);
      6'd31: u = uw(U_FINSW, R_T,   R_X1,  R_X1,  6'd0);
      6'd32: u = uw(U_CMOV,  R_T,   R_X2,  R_X2,  6'd0);
      6'd33: u = uw(U_CMOV,  R_X2,  R_X3,  R_X3,  6'd0);
      6'd34: u = uw(U_CMOV,  R_X3,  R_T,   R_T,   6'd0);
      6'd35: u = uw(U_CMOV,  R_T,   R_Z2,  R_Z2,  6'd0);
      6'd36: u = uw(U_CMOV,  R_Z2,  R_Z3,  R_Z3,  6'd0);
      6'd37: u = uw(U_CMOV,  R_Z3,  R_T,   R_T,   6'd0);
      6'd38: u = uw(U_LD1,   R_INV, R_X1,  R_X1,  6'd0);
      6'd39: u = uw(U_MUL,   R_INV, R_INV, R_INV, 6'd0);
      6'd40: u = uw(U_SKIPB, R_T,   R_X1,  R_X1,  PC_NOMUL);
      6'd41: u = uw(U_MUL,   R_INV, R_INV, R_Z2,  6'd0);
      6'd42: u = uw(U_LOOP,  R_T,   R_X1,  R_X1,  PC_INV);
      6'd43: u = uw(U_MUL,   R_X2,  R_X2,  R_INV, 6'd0);
      6'd44: u = uw(U_FRZ,   R_X2,  R_X2,  R_X2,  6'd0);
      default: u = uw(U_OUTP, R_T,  R_X2,  R_X2,  6'd0);
    endcase
    return u;
  endfunction

endpackage

### hdl/x25sm_alu.sv
// Multi-cycle GF(2^255-19) unit: add, subtract, multiply on a 32x32 multiplier, freeze.
module x25sm_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  x25sm_pkg::alu_req_t     req_i,
  input  logic [255:0]            opa_i,
  input  logic [255:0]            opb_i,
  output logic                    done_o,
  output logic [255:0]            res_o
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MUL  = 6'b000010,
    A_RED  = 6'b000100,
    A_FOLD = 6'b001000,
    A_FRZ  = 6'b010000,
    A_DONE = 6'b100000
  } alu_state_e;

  alu_state_e   state_q, state_d;
  logic [2:0]   i_q;
  logic [3:0]   j_q;
  logic [2:0]   k_q;
  logic [1:0]   f_q;
  logic [31:0]  carry_q;
  logic [5:0]   rcar_q;
  logic [261:0] acc_q;
  logic [255:0] opa_q, opb_q;
  logic [31:0]  tlo_q [8];
  logic [31:0]  thi_q [8];

  logic [31:0]  a_limb, b_limb, t_rd;
  logic [3:0]   t_addr;
  logic [63:0]  prod;
  logic [37:0]  red;
  logic [5:0]   hi;
  logic [261:0] fold;
  logic [261:0] frz_step;
  logic [255:0] frz_t;

  // Schoolbook product column: one 32x32 partial product per cycle.
  // The top limb of each row is written fresh, so it starts from zero.
  always_comb begin
    a_limb = opa_q[i_q*32 +: 32];
    b_limb = j_q[3] ? 32'd0 : opb_q[j_q[2:0]*32 +: 32];
    t_addr = {1'b0, i_q} + j_q;
    if (i_q == 3'd0 || j_q[3]) begin
      t_rd = 32'd0;
    end else begin
      t_rd = t_addr[3] ? thi_q[t_addr[2:0]] : tlo_q[t_addr[2:0]];
    end
    prod = {32'd0, a_limb} * {32'd0, b_limb} + {32'd0, t_rd} + {32'd0, carry_q};
  end

  // High half times 38 folded into the low half, one limb a cycle.
  assign red = 38'(thi_q[k_q]) * 38'd38 + 38'(tlo_q[k_q]) + 38'(rcar_q);

  // Bits above 2^256 fold back as multiples of 38.
  assign hi       = acc_q[261:256];
  assign fold     = {6'd0, acc_q[255:0]} + 262'({6'd0, hi} * 12'd38);
  assign frz_step = {7'd0, acc_q[254:0]} + (acc_q[255] ? 262'd19 : 262'd0);
  assign frz_t    = acc_q[255:0] + 256'd19;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            x25sm_pkg::ALU_ADD, x25sm_pkg::ALU_SUB: state_d = A_FOLD;
            x25sm_pkg::ALU_FRZ:                     state_d = A_FRZ;
            default:                                state_d = A_MUL;
          endcase
        end
      end
      A_MUL:  if (i_q == 3'd7 && j_q == 4'd8) state_d = A_RED;
      A_RED:  if (k_q == 3'd7) state_d = A_FOLD;
      A_FOLD: if (hi == 6'd0) state_d = A_DONE;
      A_FRZ:  if (f_q == 2'd2) state_d = A_DONE;
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      f_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        A_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          f_q <= '0;
        end
        A_MUL: begin
          if (j_q == 4'd8) begin
            j_q <= '0;
            i_q <= i_q + 3'd1;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        A_RED:   k_q <= k_q + 3'd1;
        A_FRZ:   f_q <= f_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        carry_q <= '0;
        rcar_q  <= '0;
        opa_q   <= opa_i;
        opb_q   <= (req_i.op == x25sm_pkg::ALU_MULK) ? x25sm_pkg::A24 : opb_i;
        case (req_i.op)
          x25sm_pkg::ALU_ADD: acc_q <= {6'd0, opa_i} + {6'd0, opb_i};
          x25sm_pkg::ALU_SUB: acc_q <= {6'd0, opa_i} + x25sm_pkg::FOUR_P - {6'd0, opb_i};
          default:            acc_q <= {6'd0, opa_i};
        endcase
      end
      A_MUL: begin
        if (t_addr[3]) begin
          thi_q[t_addr[2:0]] <= prod[31:0];
        end else begin
          tlo_q[t_addr[2:0]] <= prod[31:0];
        end
        carry_q <= (j_q == 4'd8) ? 32'd0 : prod[63:32];
      end
      A_RED: begin
        acc_q[k_q*32 +: 32] <= red[31:0];
        rcar_q <= red[37:32];
        if (k_q == 3'd7) begin
          acc_q[261:256] <= red[37:32];
        end
      end
      A_FOLD: if (hi != 6'd0) acc_q <= fold;
      A_FRZ: begin
        if (f_q == 2'd2) begin
          if (frz_t[255]) acc_q <= {7'd0, frz_t[254:0]};
        end else begin
          acc_q <= frz_step;
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == A_DONE);
  assign res_o  = acc_q[255:0];

endmodule

### hdl/x25519_scalar_multiply_top.sv
// X25519 scalar multiplier: word loader, microcoded sequencer, register file and output.
//
// The block takes the scalar and the peer u-coordinate as four 64-bit words each, one
// transaction per word pair; words 0 to 2 are stored, and word 3 starts a run with the
// words stored. A point with small order (bit 255 ignored) is answered by four zero
// words with the rejected flag set. Any other point runs the 255-step Montgomery ladder
// and an inversion by exponentiation, driven by a 46-step control program. Every field
// multiplication goes through one 32x32 multiplier, in partial products, reduction,
// folding and register file access. No new word is taken until the four result words
// have been delivered.
module x25519_scalar_multiply_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // word_index[1:0], scalar_word[65:2], point_word[129:66]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // out_index[1:0], result_word[65:2]
  output logic         m_axis_tuser,   // rejected
  output logic         m_axis_tlast
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [5:0]          pc_q, pc_d;
  logic [7:0]          pos_q, pos_d;
  logic                swap_q, swap_d;
  logic                cond_q, cond_d;
  logic [1:0]          oidx_q;
  logic                rej_q;
  logic [63:0]         sstore_q [4];
  logic [63:0]         pstore_q [4];
  logic [255:0]        rf_q [16];
  logic [255:0]        rda_q, rdb_q, out_q;

  x25sm_pkg::uop_t     uop;
  x25sm_pkg::alu_req_t alu_req;
  logic                alu_done;
  logic [255:0]        alu_res;
  logic                in_hs, out_hs;
  logic [1:0]          in_idx;
  logic [255:0]        point, scalar;
  logic                is_small;
  logic                sbit, ibit;
  logic                rf_we;
  logic [255:0]        rf_wd;

  assign uop    = x25sm_pkg::rom(pc_q);
  assign in_hs  = s_axis_tvalid & s_axis_tready;
  assign out_hs = m_axis_tvalid & m_axis_tready;
  assign in_idx = s_axis_tdata[1:0];

  // Point with bit 255 cleared and the clamped scalar.
  always_comb begin
    point    = {1'b0, pstore_q[3][62:0], pstore_q[2], pstore_q[1], pstore_q[0]};
    scalar   = {2'b01, sstore_q[3][61:0], sstore_q[2], sstore_q[1], sstore_q[0][63:3], 3'b000};
    is_small = 1'b0;
    for (int n = 0; n < x25sm_pkg::N_SMALL; n++) begin
      if (point == x25sm_pkg::SMALL_ORDER[n]) is_small = 1'b1;
    end
    sbit = scalar[pos_q];
    ibit = (pos_q >= 8'd8) ? 1'b1 : x25sm_pkg::INV_LOW[pos_q[2:0]];
  end

  // Field unit request.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = x25sm_pkg::ALU_ADD;
    if (state_q == S_EXEC) begin
      case (uop.op)
        x25sm_pkg::U_ADD:  begin alu_req.start = 1'b1; alu_req.op = x25sm_pkg::ALU_ADD;  end
        x25sm_pkg::U_SUB:  begin alu_req.start = 1'b1; alu_req.op = x25sm_pkg::ALU_SUB;  end
        x25sm_pkg::U_MUL:  begin alu_req.start = 1'b1; alu_req.op = x25sm_pkg::ALU_MUL;  end
        x25sm_pkg::U_MULK: begin alu_req.start = 1'b1; alu_req.op = x25sm_pkg::ALU_MULK; end
        x25sm_pkg::U_FRZ:  begin alu_req.start = 1'b1; alu_req.op = x25sm_pkg::ALU_FRZ;  end
        default: ;
      endcase
    end
  end

  x25sm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (rda_q),
    .opb_i  (rdb_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Sequencer: executes one control word, or waits for the field unit.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    pos_d   = pos_q;
    swap_d  = swap_q;
    cond_d  = cond_q;
    rf_we   = 1'b0;
    rf_wd   = rda_q;
    case (state_q)
      S_IDLE:  if (in_hs && in_idx == 2'd3) state_d = S_CHECK;
      S_CHECK: begin
        pc_d    = '0;
        state_d = is_small ? S_OUT : S_FETCH;
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        pc_d    = pc_q + 6'd1;
        state_d = S_FETCH;
        case (uop.op)
          x25sm_pkg::U_LD0: begin rf_we = 1'b1; rf_wd = '0; end
          x25sm_pkg::U_LD1: begin rf_we = 1'b1; rf_wd = 256'd1; end
          x25sm_pkg::U_LDP: begin rf_we = 1'b1; rf_wd = point; end
          x25sm_pkg::U_MOV:  rf_we = 1'b1;
          x25sm_pkg::U_CMOV: rf_we = cond_q;
          x25sm_pkg::U_SETSW: begin
            cond_d = swap_q ^ sbit;
            swap_d = sbit;
          end
          x25sm_pkg::U_FINSW: begin
            cond_d = swap_q;
            swap_d = 1'b0;
          end
          x25sm_pkg::U_LOOP: begin
            if (pos_q != 8'd0) begin
              pos_d = pos_q - 8'd1;
              pc_d  = uop.tgt;
            end else begin
              pos_d = x25sm_pkg::POS_TOP;
            end
          end
          x25sm_pkg::U_SKIPB: if (!ibit) pc_d = uop.tgt;
          x25sm_pkg::U_OUTP:  state_d = S_OUT;
          default: begin
            pc_d    = pc_q;
            state_d = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (alu_done) begin
          rf_we   = 1'b1;
          rf_wd   = alu_res;
          pc_d    = pc_q + 6'd1;
          state_d = S_FETCH;
        end
      end
      S_OUT:  if (out_hs && oidx_q == 2'd3) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      pos_q   <= x25sm_pkg::POS_TOP;
      swap_q  <= 1'b0;
      cond_q  <= 1'b0;
      oidx_q  <= '0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pos_q   <= pos_d;
      swap_q  <= swap_d;
      cond_q  <= cond_d;
      if (state_q == S_CHECK) begin
        rej_q  <= is_small;
        oidx_q <= '0;
      end else if (out_hs) begin
        oidx_q <= oidx_q + 2'd1;
      end
    end
  end

  // Word stores, register file and its registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      sstore_q[in_idx] <= s_axis_tdata[65:2];
      pstore_q[in_idx] <= s_axis_tdata[129:66];
    end
    if (rf_we) begin
      rf_q[uop.dst] <= rf_wd;
    end
    if (state_q == S_FETCH) begin
      rda_q <= rf_q[uop.sa];
      rdb_q <= rf_q[uop.sb];
    end
    if (state_q == S_CHECK) begin
      out_q <= '0;
    end else if (state_q == S_EXEC && uop.op == x25sm_pkg::U_OUTP) begin
      out_q <= rda_q;
    end
  end

  // Stream ports.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, out_q[oidx_q*64 +: 64], oidx_q};
  assign m_axis_tuser  = rej_q;
  assign m_axis_tlast  = (oidx_q == 2'd3);

endmodule
